@@ src/ifd_pkg.sv @@
package ifd_pkg;

    localparam int unsigned ByteW = 8;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_CTRL = 3'd2,
        PH_BCC1 = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_HDR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ACK_NONE = 3'd0,
        ACK_RR0  = 3'd1,
        ACK_RR1  = 3'd2,
        ACK_REJ0 = 3'd3,
        ACK_REJ1 = 3'd4
    } ack_t;

    typedef enum logic [2:0] {
        CFG_FLAG      = 3'd0,
        CFG_ESCAPE    = 3'd1,
        CFG_STUF_FLAG = 3'd2,
        CFG_STUF_ESC  = 3'd3,
        CFG_ADDRESS   = 3'd4,
        CFG_CTRL_ZERO = 3'd5,
        CFG_CTRL_ONE  = 3'd6
    } cfg_idx_t;

    localparam logic [ByteW-1:0] RstFlag     = 8'd126;
    localparam logic [ByteW-1:0] RstEscape   = 8'd125;
    localparam logic [ByteW-1:0] RstStufFlag = 8'd94;
    localparam logic [ByteW-1:0] RstStufEsc  = 8'd93;
    localparam logic [ByteW-1:0] RstAddress  = 8'd3;
    localparam logic [ByteW-1:0] RstCtrlZero = 8'd0;
    localparam logic [ByteW-1:0] RstCtrlOne  = 8'd64;

    typedef struct packed {
        logic [ByteW-1:0] flag_byte;
        logic [ByteW-1:0] escape_byte;
        logic [ByteW-1:0] stuffed_flag_code;
        logic [ByteW-1:0] stuffed_escape_code;
        logic [ByteW-1:0] address_byte;
        logic [ByteW-1:0] control_seq_zero;
        logic [ByteW-1:0] control_seq_one;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic [ByteW-1:0] data_byte;
        logic             frame_seq;
        ack_t             ack_code;
    } result_t;

endpackage

@@ src/info_frame_deframer.sv @@
// an item is registered in in_byte_reg on entry, and its result, if any, is
// registered in out_reg when the parser fires on that item
// throughput: one item per cycle unless m_ready stalls the output; the single
// per-byte state update bounds it; reset: aresetn low at a clock edge clears
// the pipeline valids and parser state and restores the default frame codes
module info_frame_deframer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_index,
    input  logic [ifd_pkg::ByteW-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ifd_pkg::ByteW-1:0] s_rx_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_kind,
    output logic [ifd_pkg::ByteW-1:0] m_data_byte,
    output logic                      m_frame_seq,
    output logic [2:0]                m_ack_code
);

    ifd_pkg::cfg_t             cfg;
    ifd_pkg::result_t          res;
    logic                      in_valid_reg, in_valid_next;
    logic [ifd_pkg::ByteW-1:0] in_byte_reg;
    logic                      out_valid_reg, out_valid_next;
    ifd_pkg::result_t          out_reg;
    logic                      advance;

    ifd_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    ifd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (advance),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = (in_valid_reg && !advance) || s_valid;
        out_valid_next = (out_valid_reg && !m_ready) || (advance && res.valid);
        if (!s_ready) begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_kind      = out_reg.kind;
    assign m_data_byte = out_reg.data_byte;
    assign m_frame_seq = out_reg.frame_seq;
    assign m_ack_code  = out_reg.ack_code;

endmodule

@@ src/ifd_cfg_regs.sv @@
module ifd_cfg_regs (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [2:0]               cfg_index,
    input  logic [ifd_pkg::ByteW-1:0] cfg_wr_data,
    output ifd_pkg::cfg_t            cfg
);

    ifd_pkg::cfg_t cfg_reg;
    ifd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (ifd_pkg::cfg_idx_t'(cfg_index))
                ifd_pkg::CFG_FLAG:      cfg_next.flag_byte           = cfg_wr_data;
                ifd_pkg::CFG_ESCAPE:    cfg_next.escape_byte         = cfg_wr_data;
                ifd_pkg::CFG_STUF_FLAG: cfg_next.stuffed_flag_code   = cfg_wr_data;
                ifd_pkg::CFG_STUF_ESC:  cfg_next.stuffed_escape_code = cfg_wr_data;
                ifd_pkg::CFG_ADDRESS:   cfg_next.address_byte        = cfg_wr_data;
                ifd_pkg::CFG_CTRL_ZERO: cfg_next.control_seq_zero    = cfg_wr_data;
                ifd_pkg::CFG_CTRL_ONE:  cfg_next.control_seq_one     = cfg_wr_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte           <= ifd_pkg::RstFlag;
            cfg_reg.escape_byte         <= ifd_pkg::RstEscape;
            cfg_reg.stuffed_flag_code   <= ifd_pkg::RstStufFlag;
            cfg_reg.stuffed_escape_code <= ifd_pkg::RstStufEsc;
            cfg_reg.address_byte        <= ifd_pkg::RstAddress;
            cfg_reg.control_seq_zero    <= ifd_pkg::RstCtrlZero;
            cfg_reg.control_seq_one     <= ifd_pkg::RstCtrlOne;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/ifd_parser.sv @@
module ifd_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ifd_pkg::cfg_t             cfg,
    input  logic                      fire,
    input  logic [ifd_pkg::ByteW-1:0] rx_byte,
    output ifd_pkg::result_t          res
);

    ifd_pkg::phase_t           phase_reg, phase_next;
    logic                      esc_reg, esc_next;
    logic [ifd_pkg::ByteW-1:0] held_reg, held_next;
    logic                      held_valid_reg, held_valid_next;
    logic [ifd_pkg::ByteW-1:0] xor_reg, xor_next;
    logic                      seq_reg, seq_next;
    logic                      expected_reg, expected_next;

    logic                      take;
    logic [ifd_pkg::ByteW-1:0] take_val;
    logic [ifd_pkg::ByteW-1:0] ctrl_sel;
    logic                      good;
    ifd_pkg::ack_t             rej_ack;

    assign ctrl_sel = seq_reg ? cfg.control_seq_one : cfg.control_seq_zero;
    assign good     = held_valid_reg && (xor_reg == held_reg);
    assign rej_ack  = expected_reg ? ifd_pkg::ACK_REJ1 : ifd_pkg::ACK_REJ0;

    // next state
    always_comb begin
        phase_next      = phase_reg;
        esc_next        = esc_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        xor_next        = xor_reg;
        seq_next        = seq_reg;
        expected_next   = expected_reg;
        take            = 1'b0;
        take_val        = rx_byte;
        unique case (phase_reg)
            ifd_pkg::PH_ADDR: begin
                if (rx_byte == cfg.address_byte) begin
                    phase_next = ifd_pkg::PH_CTRL;
                end else if (rx_byte == cfg.flag_byte) begin
                    phase_next = ifd_pkg::PH_ADDR;
                    seq_next   = 1'b0;
                end else begin
                    phase_next = ifd_pkg::PH_HUNT;
                end
            end
            ifd_pkg::PH_CTRL: begin
                if (rx_byte == cfg.control_seq_zero) begin
                    seq_next   = 1'b0;
                    phase_next = ifd_pkg::PH_BCC1;
                end else if (rx_byte == cfg.control_seq_one) begin
                    seq_next   = 1'b1;
                    phase_next = ifd_pkg::PH_BCC1;
                end else if (rx_byte == cfg.flag_byte) begin
                    phase_next = ifd_pkg::PH_ADDR;
                    seq_next   = 1'b0;
                end else begin
                    phase_next = ifd_pkg::PH_HUNT;
                end
            end
            ifd_pkg::PH_BCC1: begin
                if (rx_byte == (cfg.address_byte ^ ctrl_sel)) begin
                    phase_next      = ifd_pkg::PH_DATA;
                    esc_next        = 1'b0;
                    held_valid_next = 1'b0;
                    held_next       = '0;
                    xor_next        = '0;
                end else if (rx_byte == cfg.flag_byte) begin
                    phase_next = ifd_pkg::PH_ADDR;
                    seq_next   = 1'b0;
                end else begin
                    phase_next = ifd_pkg::PH_HUNT;
                end
            end
            ifd_pkg::PH_DATA: begin
                if (rx_byte == cfg.flag_byte) begin
                    esc_next   = 1'b0;
                    phase_next = ifd_pkg::PH_HUNT;
                    if (good) begin
                        expected_next = ~expected_reg;
                    end
                end else if (esc_reg && rx_byte == cfg.stuffed_escape_code) begin
                    esc_next = 1'b0;
                    take     = 1'b1;
                    take_val = cfg.escape_byte;
                end else if (esc_reg && rx_byte == cfg.stuffed_flag_code) begin
                    esc_next = 1'b0;
                    take     = 1'b1;
                    take_val = cfg.flag_byte;
                end else if (rx_byte == cfg.escape_byte) begin
                    esc_next = 1'b1;
                end else begin
                    esc_next = 1'b0;
                    take     = 1'b1;
                end
            end
            default: begin
                if (rx_byte == cfg.flag_byte) begin
                    phase_next = ifd_pkg::PH_ADDR;
                    seq_next   = 1'b0;
                end else begin
                    phase_next = ifd_pkg::PH_HUNT;
                end
            end
        endcase
        if (take) begin
            if (held_valid_reg) begin
                xor_next = xor_reg ^ held_reg;
            end
            held_next       = take_val;
            held_valid_next = 1'b1;
        end
    end

    // result
    always_comb begin
        res           = '0;
        res.kind      = ifd_pkg::KIND_DATA;
        res.ack_code  = ifd_pkg::ACK_NONE;
        res.frame_seq = seq_reg;
        unique case (phase_reg)
            ifd_pkg::PH_ADDR, ifd_pkg::PH_CTRL, ifd_pkg::PH_BCC1: begin
                if (phase_next == ifd_pkg::PH_HUNT) begin
                    res.valid    = 1'b1;
                    res.kind     = ifd_pkg::KIND_HDR;
                    res.ack_code = rej_ack;
                end
            end
            ifd_pkg::PH_DATA: begin
                if (rx_byte == cfg.flag_byte) begin
                    res.valid = 1'b1;
                    if (good) begin
                        res.kind     = ifd_pkg::KIND_GOOD;
                        res.ack_code = expected_reg ? ifd_pkg::ACK_RR0 : ifd_pkg::ACK_RR1;
                    end else begin
                        res.kind     = ifd_pkg::KIND_BAD;
                        res.ack_code = rej_ack;
                    end
                end else if (take && held_valid_reg) begin
                    res.valid     = 1'b1;
                    res.data_byte = held_reg;
                end
            end
            default: begin
                res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= ifd_pkg::PH_HUNT;
            esc_reg        <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            xor_reg        <= '0;
            seq_reg        <= 1'b0;
            expected_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            esc_reg        <= esc_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            xor_reg        <= xor_next;
            seq_reg        <= seq_next;
            expected_reg   <= expected_next;
        end
    end

    a_good_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.valid && res.kind == ifd_pkg::KIND_GOOD
        |=> expected_reg != $past(expected_reg))
        else $error("good frame did not toggle expected number");

    a_data_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.kind == ifd_pkg::KIND_DATA
        |-> phase_reg == ifd_pkg::PH_DATA && held_valid_reg)
        else $error("payload item outside payload field");

    a_hdr_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.kind == ifd_pkg::KIND_HDR
        |-> phase_reg == ifd_pkg::PH_ADDR || phase_reg == ifd_pkg::PH_CTRL
            || phase_reg == ifd_pkg::PH_BCC1)
        else $error("header error outside header");

    a_end_hunts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.valid && res.kind != ifd_pkg::KIND_DATA
        |=> phase_reg == ifd_pkg::PH_HUNT)
        else $error("no return to hunting after frame end");

endmodule
